>>> rtl/qu8add_pkg.sv
`default_nettype none

package qu8add_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CHANNELS   = 64;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Field and register widths
    localparam int VAL_W   = 8;
    localparam int CHF_W   = 6;
    localparam int SEL_W   = 3;
    localparam int COEF_W  = 32;
    localparam int CHC_W   = 7;
    localparam int SPC_W   = 25;
    localparam int POS_W   = 24;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 32;

    // Datapath widths: element times coefficient, dequantized sum, scale half, partial product, accumulator
    localparam int DQ_W    = 42;
    localparam int SUM_W   = 43;
    localparam int MOP_W   = 17;
    localparam int PROD_W  = 60;
    localparam int ACC_W   = 76;

    // Operation codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_COEF = 1'b1;

    // Coefficient selects
    localparam logic [SEL_W-1:0] SEL_A_SCALE   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_A_SHIFT   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B_SCALE   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_B_SHIFT   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_OUT_SCALE = 3'd4;
    localparam logic [SEL_W-1:0] SEL_OUT_SHIFT = 3'd5;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_LAYOUT        = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SPATIAL_COUNT = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_UPPER_LIMIT   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic rd_en;    // latch operands, read coefficient tables
        logic wr_en;    // write one coefficient
        logic do_prod;  // scale each operand
        logic do_sum;   // add dequantized operands
        logic do_mlo;   // low half of output scale product plus shift
        logic do_mhi;   // add high half of output scale product
        logic do_out;   // round, clamp, load result register
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> rtl/qu8add_ctrl.sv
`default_nettype none

module qu8add_ctrl #(
    parameter int MAX_CHANNELS = qu8add_pkg::DEF_MAX_CHANNELS,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_operation,
    input  wire [qu8add_pkg::CHF_W-1:0]      i_coef_channel,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [qu8add_pkg::CHF_W-1:0]     o_result_channel,
    output logic                             o_tensor_end,
    input  wire                              i_layout,
    input  wire [qu8add_pkg::CHC_W-1:0]      i_channel_count,
    input  wire [qu8add_pkg::SPC_W-1:0]      i_spatial_count,
    output qu8add_pkg::t_dp_cmd              o_cmd,
    output logic [CH_W-1:0]                  o_rd_addr
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PROD = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MLO  = 3'd3;
    localparam logic [2:0] ST_MHI  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [qu8add_pkg::SPC_W-1:0] SP_MAX = 25'h1000000;

    logic [2:0]                     r_state, n_state;
    logic [CH_W-1:0]                r_ch, n_ch;
    logic [qu8add_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [CH_W-1:0]                r_item_ch;
    logic                           r_item_end;
    logic                           r_out_valid;
    logic [qu8add_pkg::CHF_W-1:0]   r_out_ch;
    logic                           r_out_end;

    logic [31:0]                    w_cnt;
    logic [CH_W-1:0]                w_nch_m1;
    logic [qu8add_pkg::POS_W-1:0]   w_nsp_m1;
    logic [CH_W-1:0]                w_cur_ch;
    logic                           w_last_ch, w_last_pos;
    logic                           w_accept, w_data_acc, w_out_free;

    assign w_cnt = 32'(i_channel_count);

    always_comb begin
        if (w_cnt == 32'd0) begin
            w_nch_m1 = '0;
        end else if (w_cnt > 32'(MAX_CHANNELS)) begin
            w_nch_m1 = CH_W'(MAX_CHANNELS - 1);
        end else begin
            w_nch_m1 = CH_W'(w_cnt - 32'd1);
        end
        if (i_spatial_count == '0) begin
            w_nsp_m1 = '0;
        end else if (i_spatial_count > SP_MAX) begin
            w_nsp_m1 = '1;
        end else begin
            w_nsp_m1 = qu8add_pkg::POS_W'(i_spatial_count - 25'd1);
        end
    end

    assign w_last_ch  = (r_ch >= w_nch_m1);
    assign w_last_pos = (r_pos >= w_nsp_m1);
    assign w_cur_ch   = w_last_ch ? w_nch_m1 : r_ch;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_data_acc = w_accept && (i_operation == qu8add_pkg::OP_DATA);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_en   = w_data_acc;
        o_cmd.wr_en   = w_accept && (i_operation == qu8add_pkg::OP_COEF)
                        && (32'(i_coef_channel) < 32'(MAX_CHANNELS));
        o_cmd.do_prod = (r_state == ST_PROD);
        o_cmd.do_sum  = (r_state == ST_SUM);
        o_cmd.do_mlo  = (r_state == ST_MLO);
        o_cmd.do_mhi  = (r_state == ST_MHI);
        o_cmd.do_out  = (r_state == ST_OUT) && w_out_free;
    end

    assign o_rd_addr = w_cur_ch;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_data_acc) n_state = ST_PROD;
            end
            ST_PROD: n_state = ST_SUM;
            ST_SUM:  n_state = ST_MLO;
            ST_MLO:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance the channel and position counters on each data word
    always_comb begin
        n_ch  = r_ch;
        n_pos = r_pos;
        if (w_data_acc) begin
            if (i_layout == 1'b0) begin
                if (w_last_pos) begin
                    n_pos = '0;
                    n_ch  = w_last_ch ? '0 : r_ch + CH_W'(1);
                end else begin
                    n_pos = r_pos + qu8add_pkg::POS_W'(1);
                end
            end else begin
                if (w_last_ch) begin
                    n_ch  = '0;
                    n_pos = w_last_pos ? '0 : r_pos + qu8add_pkg::POS_W'(1);
                end else begin
                    n_ch = r_ch + CH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_pos   <= n_pos;
            if (o_cmd.do_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_acc) begin
            r_item_ch  <= w_cur_ch;
            r_item_end <= w_last_ch && w_last_pos;
        end
        if (o_cmd.do_out) begin
            r_out_ch  <= qu8add_pkg::CHF_W'(r_item_ch);
            r_out_end <= r_item_end;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_channel = r_out_ch;
    assign o_tensor_end     = r_out_end;

endmodule

`default_nettype wire

>>> rtl/qu8add_dp.sv
`default_nettype none

module qu8add_dp #(
    parameter int MAX_CHANNELS   = qu8add_pkg::DEF_MAX_CHANNELS,
    parameter int COEF_FRAC_BITS = qu8add_pkg::DEF_COEF_FRAC_BITS,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire                                    i_clk,
    input  qu8add_pkg::t_dp_cmd                    i_cmd,
    input  wire [CH_W-1:0]                         i_rd_addr,
    input  wire [qu8add_pkg::VAL_W-1:0]            i_a_value,
    input  wire [qu8add_pkg::VAL_W-1:0]            i_b_value,
    input  wire [qu8add_pkg::CHF_W-1:0]            i_coef_channel,
    input  wire [qu8add_pkg::SEL_W-1:0]            i_coef_select,
    input  wire signed [qu8add_pkg::COEF_W-1:0]    i_coef_value,
    input  wire [qu8add_pkg::VAL_W-1:0]            i_upper_limit,
    output logic [qu8add_pkg::VAL_W-1:0]           o_result_value
);

    localparam int ACC_W = qu8add_pkg::ACC_W;
    localparam int RW    = 2 * COEF_FRAC_BITS;
    localparam logic [RW-1:0] HALF = RW'(1) << (RW - 1);

    // Coefficient tables, one entry per channel
    logic [31:0] r_mem_as  [MAX_CHANNELS];
    logic [31:0] r_mem_ash [MAX_CHANNELS];
    logic [31:0] r_mem_bs  [MAX_CHANNELS];
    logic [31:0] r_mem_bsh [MAX_CHANNELS];
    logic [31:0] r_mem_os  [MAX_CHANNELS];
    logic [31:0] r_mem_osh [MAX_CHANNELS];

    logic [CH_W-1:0]                         w_waddr;
    logic [qu8add_pkg::VAL_W-1:0]            r_a, r_b;
    logic signed [31:0]                      r_as, r_ash, r_bs, r_bsh, r_os, r_osh;
    logic signed [qu8add_pkg::DQ_W-1:0]      r_pa, r_pb;
    logic signed [qu8add_pkg::SUM_W-1:0]     r_s;
    logic signed [ACC_W-1:0]                 r_acc;
    logic [qu8add_pkg::VAL_W-1:0]            r_result;

    logic signed [qu8add_pkg::DQ_W-2:0]      w_ma, w_mb;
    logic signed [qu8add_pkg::MOP_W-1:0]     w_mop;
    logic signed [qu8add_pkg::PROD_W-1:0]    w_prod;
    logic signed [ACC_W-1:0]                 w_n, w_nr;
    logic [RW-1:0]                           w_rem;
    logic                                    w_up;
    logic [qu8add_pkg::VAL_W-1:0]            w_sat, w_res;

    assign w_waddr = CH_W'(i_coef_channel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            case (i_coef_select)
                qu8add_pkg::SEL_A_SCALE:   r_mem_as[w_waddr]  <= i_coef_value;
                qu8add_pkg::SEL_A_SHIFT:   r_mem_ash[w_waddr] <= i_coef_value;
                qu8add_pkg::SEL_B_SCALE:   r_mem_bs[w_waddr]  <= i_coef_value;
                qu8add_pkg::SEL_B_SHIFT:   r_mem_bsh[w_waddr] <= i_coef_value;
                qu8add_pkg::SEL_OUT_SCALE: r_mem_os[w_waddr]  <= i_coef_value;
                qu8add_pkg::SEL_OUT_SHIFT: r_mem_osh[w_waddr] <= i_coef_value;
                default: ;
            endcase
        end
        if (i_cmd.rd_en) begin
            r_a   <= i_a_value;
            r_b   <= i_b_value;
            r_as  <= $signed(r_mem_as[i_rd_addr]);
            r_ash <= $signed(r_mem_ash[i_rd_addr]);
            r_bs  <= $signed(r_mem_bs[i_rd_addr]);
            r_bsh <= $signed(r_mem_bsh[i_rd_addr]);
            r_os  <= $signed(r_mem_os[i_rd_addr]);
            r_osh <= $signed(r_mem_osh[i_rd_addr]);
        end
    end

    assign w_ma = $signed({1'b0, r_a}) * r_as;
    assign w_mb = $signed({1'b0, r_b}) * r_bs;

    // Output scale split into an unsigned low half and a signed high half
    assign w_mop  = i_cmd.do_mlo ? $signed({1'b0, r_os[15:0]})
                                 : $signed({r_os[31], r_os[31:16]});
    assign w_prod = r_s * w_mop;

    // Round half to even at 2*COEF_FRAC_BITS fraction bits, then clamp
    assign w_n   = r_acc >>> RW;
    assign w_rem = r_acc[RW-1:0];
    assign w_up  = (w_rem > HALF) || ((w_rem == HALF) && w_n[0]);
    assign w_nr  = w_n + $signed({{(ACC_W-1){1'b0}}, w_up});

    always_comb begin
        if (w_nr[ACC_W-1]) begin
            w_sat = '0;
        end else if (|w_nr[ACC_W-2:qu8add_pkg::VAL_W]) begin
            w_sat = '1;
        end else begin
            w_sat = w_nr[qu8add_pkg::VAL_W-1:0];
        end
        w_res = (w_sat > i_upper_limit) ? i_upper_limit : w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_prod) begin
            r_pa <= qu8add_pkg::DQ_W'(w_ma) + qu8add_pkg::DQ_W'(r_ash);
            r_pb <= qu8add_pkg::DQ_W'(w_mb) + qu8add_pkg::DQ_W'(r_bsh);
        end
        if (i_cmd.do_sum) begin
            r_s <= qu8add_pkg::SUM_W'(r_pa) + qu8add_pkg::SUM_W'(r_pb);
        end
        if (i_cmd.do_mlo) begin
            r_acc <= ACC_W'(w_prod) + (ACC_W'(r_osh) <<< COEF_FRAC_BITS);
        end
        if (i_cmd.do_mhi) begin
            r_acc <= r_acc + (ACC_W'(w_prod) <<< 16);
        end
        if (i_cmd.do_out) begin
            r_result <= w_res;
        end
    end

    assign o_result_value = r_result;

endmodule

`default_nettype wire

>>> rtl/quantized_u8_tensor_add_unit.sv
// Each data word accepted while idle runs a five-step sequence around the shared output-scale multiplier
//   (product, sum, low half, high half, output) into its output register; the output step waits while a
//   stalled result is held, and input stalls until the word is done. A coefficient word gives no output.
// Reset (synchronous, active low): idle, counters at zero, configuration registers at
//   their defaults; the coefficient tables hold nothing until written.
`default_nettype none

module quantized_u8_tensor_add_unit #(
    parameter int MAX_CHANNELS   = qu8add_pkg::DEF_MAX_CHANNELS,
    parameter int COEF_FRAC_BITS = qu8add_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // Input word channel
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire                                   i_operation,
    input  wire [qu8add_pkg::VAL_W-1:0]           i_a_value,
    input  wire [qu8add_pkg::VAL_W-1:0]           i_b_value,
    input  wire [qu8add_pkg::CHF_W-1:0]           i_coef_channel,
    input  wire [qu8add_pkg::SEL_W-1:0]           i_coef_select,
    input  wire signed [qu8add_pkg::COEF_W-1:0]   i_coef_value,
    // Result word channel
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [qu8add_pkg::VAL_W-1:0]          o_result_value,
    output logic [qu8add_pkg::CHF_W-1:0]          o_result_channel,
    output logic                                  o_tensor_end,
    // Configuration write channel
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [qu8add_pkg::CFGI_W-1:0]          i_cfg_index,
    input  wire [qu8add_pkg::CFGD_W-1:0]          i_cfg_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Configuration registers
    logic                            r_layout;
    logic [qu8add_pkg::CHC_W-1:0]    r_channel_count;
    logic [qu8add_pkg::SPC_W-1:0]    r_spatial_count;
    logic [qu8add_pkg::VAL_W-1:0]    r_upper_limit;

    qu8add_pkg::t_dp_cmd             w_cmd;
    logic [CH_W-1:0]                 w_rd_addr;

    // Configuration writes are always taken; the user must send them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout        <= 1'b0;
            r_channel_count <= qu8add_pkg::CHC_W'(1);
            r_spatial_count <= qu8add_pkg::SPC_W'(1);
            r_upper_limit   <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                qu8add_pkg::CFG_LAYOUT:
                    r_layout <= i_cfg_data[0];
                qu8add_pkg::CFG_CHANNEL_COUNT:
                    r_channel_count <= i_cfg_data[qu8add_pkg::CHC_W-1:0];
                qu8add_pkg::CFG_SPATIAL_COUNT:
                    r_spatial_count <= i_cfg_data[qu8add_pkg::SPC_W-1:0];
                qu8add_pkg::CFG_UPPER_LIMIT:
                    r_upper_limit <= i_cfg_data[qu8add_pkg::VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: handshakes, channel tracking and step commands
    qu8add_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_coef_channel   (i_coef_channel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_channel (o_result_channel),
        .o_tensor_end     (o_tensor_end),
        .i_layout         (r_layout),
        .i_channel_count  (r_channel_count),
        .i_spatial_count  (r_spatial_count),
        .o_cmd            (w_cmd),
        .o_rd_addr        (w_rd_addr)
    );

    // Arithmetic: coefficient tables, dequantize, requantize, round and clamp
    qu8add_dp #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .i_a_value      (i_a_value),
        .i_b_value      (i_b_value),
        .i_coef_channel (i_coef_channel),
        .i_coef_select  (i_coef_select),
        .i_coef_value   (i_coef_value),
        .i_upper_limit  (r_upper_limit),
        .o_result_value (o_result_value)
    );

endmodule

`default_nettype wire
